### rtl/utf8_decoder_with_replacement_assert.svh
// Assertion macros for the UTF-8 decoder checker.
// Depends on nothing; included by the checker file.
`ifndef UTF8_DECODER_WITH_REPLACEMENT_ASSERT_SVH
`define UTF8_DECODER_WITH_REPLACEMENT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UTF8R_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("utf8 decoder assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define UTF8R_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("utf8 decoder assertion failed");

`endif

### rtl/utf8r_pkg.sv
// Shared types, constants and the lead byte classifier of the UTF-8 decoder.
// Used by the decode stage, the output stage, the interfaces and the checker.
package utf8r_pkg;

  localparam int UnitW  = 21;
  localparam int ByteW  = 8;
  localparam int NSlots = 4;
  localparam int CntW   = 3;

  typedef logic [UnitW-1:0] unit_t;
  typedef logic [ByteW-1:0] byte_t;
  typedef logic [CntW-1:0]  cnt_t;

  localparam unit_t ReplChar  = 21'h00FFFD;
  localparam unit_t MaxCp     = 21'h10FFFF;
  localparam unit_t HiSurBase = 21'h00D800;
  localparam unit_t LoSurBase = 21'h00DC00;
  localparam unit_t SurLast   = 21'h00DFFF;
  localparam unit_t SuppBase  = 21'h010000;
  localparam unit_t Min3Byte  = 21'h000800;
  localparam unit_t BmpLast   = 21'h00FFFF;
  localparam byte_t MinLead2  = 8'hC2;
  localparam byte_t MaxLead2  = 8'hDF;
  localparam byte_t MaxLead3  = 8'hEF;
  localparam byte_t MaxLead4  = 8'hF4;

  // Result units caused by one input item, ready for the output stage.
  typedef struct packed {
    cnt_t                   cnt;
    logic                   eot;
    unit_t [NSlots-1:0]     unit;
    logic  [NSlots-1:0]     repl;
  } bundle_t;

  // Sequence length announced by a lead byte; zero for a byte that cannot lead.
  function automatic logic [2:0] lead_len(input byte_t b);
    logic [2:0] len;
    len = 3'd0;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if (b >= MinLead2 && b <= MaxLead2) begin
      len = 3'd2;
    end else if (b > MaxLead2 && b <= MaxLead3) begin
      len = 3'd3;
    end else if (b > MaxLead3 && b <= MaxLead4) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

### rtl/utf8r_if.sv
// Handshake channels of the UTF-8 decoder: byte input and code unit output.
// Depends on utf8r_pkg for the payload types.
interface utf8r_in_if;
  import utf8r_pkg::*;
  logic  valid;
  logic  ready;
  byte_t in_byte;
  logic  end_of_text;
  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface utf8r_out_if;
  import utf8r_pkg::*;
  logic  valid;
  logic  ready;
  unit_t code_unit;
  logic  is_replacement;
  logic  last_of_run;
  logic  text_done;
  modport source (output valid, output code_unit, output is_replacement,
                  output last_of_run, output text_done, input ready);
  modport sink (input valid, input code_unit, input is_replacement,
                input last_of_run, input text_done, output ready);
endinterface

### rtl/utf8r_seq.sv
// Decode stage: sequence state registers, mode register and the per-item decode.
// Depends on utf8r_pkg; feeds a bundle of up to four units to utf8r_emit.
module utf8r_seq import utf8r_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    cfg_wr_en,
  input  logic    cfg_wr_data,
  input  logic    take,
  input  byte_t   in_byte,
  input  logic    end_of_text,
  output bundle_t bundle
);

  logic       wide_r;
  logic [1:0] pend_r, pend_nxt;
  logic [2:0] exp_r, exp_nxt;
  unit_t      acc_r, acc_nxt;

  logic       is_cont;
  logic [2:0] llen;
  unit_t      lead_bits;
  unit_t      acc_shift;
  logic [1:0] pend_inc;
  logic       seq_done;
  logic       seq_ok;
  cnt_t       nrep;
  logic       has_cp;
  unit_t      cp;
  logic       two_units;
  cnt_t       ncp;
  unit_t      supp_off;
  unit_t      unit0;
  unit_t      unit1;

  // Decode one byte against the sequence in progress.
  always_comb begin
    is_cont   = (in_byte[7:6] == 2'b10);
    llen      = lead_len(in_byte);
    acc_shift = {acc_r[UnitW-7:0], in_byte[5:0]};
    pend_inc  = pend_r + 2'd1;
    seq_done  = ({1'b0, pend_inc} >= exp_r) || (pend_inc == 2'd0);

    // Payload bits of a lead byte by its length.
    unique case (llen)
      3'd2:    lead_bits = unit_t'(in_byte[4:0]);
      3'd3:    lead_bits = unit_t'(in_byte[3:0]);
      default: lead_bits = unit_t'(in_byte[2:0]);
    endcase

    // Overlong, surrogate and range checks on a complete sequence.
    seq_ok = 1'b1;
    if (exp_r == 3'd3 && acc_shift < Min3Byte) begin
      seq_ok = 1'b0;
    end
    if (exp_r == 3'd4 && acc_shift < SuppBase) begin
      seq_ok = 1'b0;
    end
    if (acc_shift >= HiSurBase && acc_shift <= SurLast) begin
      seq_ok = 1'b0;
    end
    if (acc_shift > MaxCp) begin
      seq_ok = 1'b0;
    end

    nrep     = '0;
    has_cp   = 1'b0;
    cp       = unit_t'(in_byte);
    pend_nxt = 2'd0;
    exp_nxt  = 3'd0;
    acc_nxt  = '0;

    if (pend_r != 2'd0 && is_cont) begin
      // Continuation of the sequence in progress.
      if (seq_done) begin
        if (seq_ok) begin
          has_cp = 1'b1;
          cp     = acc_shift;
        end else begin
          nrep = exp_r;
        end
      end else if (end_of_text) begin
        nrep = {1'b0, pend_inc};
      end else begin
        pend_nxt = pend_inc;
        exp_nxt  = exp_r;
        acc_nxt  = acc_shift;
      end
    end else begin
      // Buffered bytes of a broken sequence are replaced, then a new lead.
      nrep = {1'b0, pend_r};
      if (llen == 3'd0) begin
        nrep = nrep + 3'd1;
      end else if (llen == 3'd1) begin
        has_cp = 1'b1;
      end else if (end_of_text) begin
        nrep = nrep + 3'd1;
      end else begin
        pend_nxt = 2'd1;
        exp_nxt  = llen;
        acc_nxt  = lead_bits;
      end
    end

    // UTF-16 mode splits a supplementary code point into a surrogate pair.
    two_units = has_cp && !wide_r && (cp > BmpLast);
    supp_off  = cp - SuppBase;
    unit0     = two_units ? (HiSurBase + unit_t'(supp_off[19:10])) : cp;
    unit1     = LoSurBase + unit_t'(cp[9:0]);
    ncp       = has_cp ? (two_units ? cnt_t'(2) : cnt_t'(1)) : cnt_t'(0);

    // Replacements come first, then the code point units.
    bundle.cnt = nrep + ncp;
    bundle.eot = end_of_text;
    for (int i = 0; i < NSlots; i++) begin
      if (cnt_t'(i) < nrep) begin
        bundle.unit[i] = ReplChar;
        bundle.repl[i] = 1'b1;
      end else if (cnt_t'(i) == nrep) begin
        bundle.unit[i] = unit0;
        bundle.repl[i] = 1'b0;
      end else begin
        bundle.unit[i] = unit1;
        bundle.repl[i] = 1'b0;
      end
    end
  end

  // Mode register and sequence state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r <= 1'b1;
      pend_r <= 2'd0;
      exp_r  <= 3'd0;
      acc_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        wide_r <= cfg_wr_data;
      end
      if (take) begin
        pend_r <= pend_nxt;
        exp_r  <= exp_nxt;
        acc_r  <= acc_nxt;
      end
    end
  end

endmodule

### rtl/utf8r_emit.sv
// Output stage: result register that holds one item's units and sends them in order.
// Depends on utf8r_pkg and the utf8r_out_if channel.
module utf8r_emit import utf8r_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  bundle_t            bundle,
  input  logic               take,
  output logic               can_take,
  utf8r_out_if.source        out_ch
);

  unit_t [NSlots-1:0] unit_r;
  logic  [NSlots-1:0] repl_r;
  cnt_t               left_r;
  logic               eot_r;
  logic               busy;
  logic               last;

  // A new item loads while the final unit of the previous one leaves.
  always_comb begin
    busy                  = (left_r != '0);
    last                  = (left_r == cnt_t'(1));
    can_take              = !busy || (out_ch.ready && last);
    out_ch.valid          = busy;
    out_ch.code_unit      = unit_r[0];
    out_ch.is_replacement = repl_r[0];
    out_ch.last_of_run    = last;
    out_ch.text_done      = last && eot_r;
  end

  // Count of units still to send.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (take) begin
      left_r <= bundle.cnt;
    end else if (busy && out_ch.ready) begin
      left_r <= left_r - cnt_t'(1);
    end
  end

  // Unit slots shift toward slot zero as units are taken.
  always_ff @(posedge clk) begin
    if (take) begin
      unit_r <= bundle.unit;
      repl_r <= bundle.repl;
      eot_r  <= bundle.eot;
    end else if (busy && out_ch.ready) begin
      unit_r <= {unit_t'(0), unit_r[NSlots-1:1]};
      repl_r <= {1'b0, repl_r[NSlots-1:1]};
    end
  end

endmodule

### rtl/utf8_decoder_with_replacement.sv
// Streaming UTF-8 decoder with U+FFFD replacement.
// in_ch carries one byte per item with an end_of_text flag; out_ch carries
// 21-bit code units, each flagged as replacement, last of its byte's run and
// last of the text. cfg_wr_en/cfg_wr_data write the unit mode: 1 gives one
// unit per code point, 0 gives UTF-16 units with surrogate pairs.
// An accepted byte is decoded in the cycle it is accepted; its first unit is
// valid on out_ch in the next cycle. A byte that only extends a sequence gives
// no unit. A byte gives up to four units, sent one per cycle while out_ch.ready
// is high; the input takes one byte per cycle while each byte gives at most one
// unit and out_ch.ready is high, and the next byte is taken as the final unit
// of the byte before leaves, set by the single result register.
// Reset clears the sequence in progress and the result register and sets the
// mode to one unit per code point. While out_ch.ready is low the current
// unit holds and in_ch.ready drops once the result register is full.
// Depends on utf8r_pkg, utf8r_if, utf8r_seq and utf8r_emit.
module utf8_decoder_with_replacement import utf8r_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  utf8r_in_if.sink    in_ch,
  utf8r_out_if.source out_ch
);

  bundle_t bundle;
  logic    take;
  logic    can_take;

  // Input handshake.
  assign in_ch.ready = can_take;
  assign take        = in_ch.valid && can_take;

  utf8r_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .take        (take),
    .in_byte     (in_ch.in_byte),
    .end_of_text (in_ch.end_of_text),
    .bundle      (bundle)
  );

  utf8r_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .bundle   (bundle),
    .take     (take),
    .can_take (can_take),
    .out_ch   (out_ch)
  );

endmodule

### rtl/utf8r_checker.sv
// Port-level checker for the UTF-8 decoder, bound to the top level.
// Depends on utf8r_pkg and the assertion macros header.
`include "utf8_decoder_with_replacement_assert.svh"

module utf8r_checker import utf8r_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  out_valid,
  input logic  out_ready,
  input unit_t code_unit,
  input logic  is_replacement,
  input logic  last_of_run,
  input logic  text_done
);

  // A stalled unit stays in place.
  `UTF8R_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(code_unit) && $stable(is_replacement))

  // Every replacement unit carries U+FFFD.
  `UTF8R_ASSERT_NOW(a_repl_value, clk, rst_n, out_valid && is_replacement, code_unit == ReplChar)

  // The end of the text also ends that byte's run.
  `UTF8R_ASSERT_NOW(a_done_last, clk, rst_n, out_valid && text_done, last_of_run)

  // A high surrogate is always followed by its low half in the same run.
  `UTF8R_ASSERT_NOW(a_high_not_last, clk, rst_n, out_valid && !is_replacement && code_unit >= HiSurBase && code_unit < LoSurBase, !last_of_run)

endmodule

bind utf8_decoder_with_replacement utf8r_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .code_unit      (out_ch.code_unit),
  .is_replacement (out_ch.is_replacement),
  .last_of_run    (out_ch.last_of_run),
  .text_done      (out_ch.text_done)
);
